// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define JBSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("join_block_size_scan: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define JBSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("join_block_size_scan: next-cycle check failed");

`endif

// ----- src/jbss_pkg.sv -----
`timescale 1ns / 1ps

package jbss_pkg;

    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_KEY_BITS    = 32;
    localparam int IN_KEY_BITS     = 32;
    localparam int INDEX_BITS      = 10;
    localparam int CNT_BITS        = 11;
    localparam int TOTAL_BITS      = 19;
    localparam int PROD_BITS       = 2 * CNT_BITS;
    localparam int FLAG_BITS       = 3;

    localparam int FLAG_TAB     = 0;
    localparam int FLAG_FRESH   = 1;
    localparam int FLAG_CONTRIB = 2;

    localparam logic [CNT_BITS-1:0]   CNT_MAX   = '1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic key;
        logic flag;
        logic height;
        logic width;
    } wr_en_t;

    typedef struct packed {
        logic start;
        logic clear;
    } scan_ctl_t;

    typedef struct packed {
        logic busy;
        logic finish;
    } scan_stat_t;

endpackage

// ----- src/jbss_store.sv -----
`timescale 1ns / 1ps

module jbss_store #(
    parameter int MAX_ENTRIES = jbss_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = jbss_pkg::DEF_KEY_BITS
) (
    input  logic                            clk,
    input  logic                            rd_en,
    input  logic [$clog2(MAX_ENTRIES)-1:0]  rd_addr,
    input  jbss_pkg::wr_en_t                wr_en,
    input  logic [$clog2(MAX_ENTRIES)-1:0]  wr_addr,
    input  logic [KEY_BITS-1:0]             wr_key,
    input  logic [jbss_pkg::FLAG_BITS-1:0]  wr_flag,
    input  logic [jbss_pkg::CNT_BITS-1:0]   wr_height,
    input  logic [jbss_pkg::CNT_BITS-1:0]   wr_width,
    output logic [KEY_BITS-1:0]             rd_key,
    output logic [jbss_pkg::FLAG_BITS-1:0]  rd_flag,
    output logic [jbss_pkg::CNT_BITS-1:0]   rd_height,
    output logic [jbss_pkg::CNT_BITS-1:0]   rd_width
);

    logic [KEY_BITS-1:0]            key_mem    [MAX_ENTRIES];
    logic [jbss_pkg::FLAG_BITS-1:0] flag_mem   [MAX_ENTRIES];
    logic [jbss_pkg::CNT_BITS-1:0]  height_mem [MAX_ENTRIES];
    logic [jbss_pkg::CNT_BITS-1:0]  width_mem  [MAX_ENTRIES];

    logic [KEY_BITS-1:0]            rd_key_reg;
    logic [jbss_pkg::FLAG_BITS-1:0] rd_flag_reg;
    logic [jbss_pkg::CNT_BITS-1:0]  rd_height_reg;
    logic [jbss_pkg::CNT_BITS-1:0]  rd_width_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en.key)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr_en.flag)
        begin
            flag_mem[wr_addr] <= wr_flag;
        end
        if (wr_en.height)
        begin
            height_mem[wr_addr] <= wr_height;
        end
        if (wr_en.width)
        begin
            width_mem[wr_addr] <= wr_width;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key_reg    <= key_mem[rd_addr];
            rd_flag_reg   <= flag_mem[rd_addr];
            rd_height_reg <= height_mem[rd_addr];
            rd_width_reg  <= width_mem[rd_addr];
        end
    end

    assign rd_key    = rd_key_reg;
    assign rd_flag   = rd_flag_reg;
    assign rd_height = rd_height_reg;
    assign rd_width  = rd_width_reg;

endmodule

// ----- src/jbss_scan.sv -----
`timescale 1ns / 1ps

module jbss_scan #(
    parameter int MAX_ENTRIES = jbss_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = jbss_pkg::DEF_KEY_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  jbss_pkg::scan_ctl_t               ctl,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]  count,
    input  logic [KEY_BITS-1:0]               rd_key,
    input  logic [jbss_pkg::FLAG_BITS-1:0]    rd_flag,
    input  logic [jbss_pkg::CNT_BITS-1:0]     rd_height,
    input  logic [jbss_pkg::CNT_BITS-1:0]     rd_width,
    output logic                              rd_en,
    output logic [$clog2(MAX_ENTRIES)-1:0]    rd_addr,
    output jbss_pkg::wr_en_t                  wr_en,
    output logic [$clog2(MAX_ENTRIES)-1:0]    wr_addr,
    output logic [jbss_pkg::FLAG_BITS-1:0]    wr_flag,
    output logic [jbss_pkg::CNT_BITS-1:0]     wr_height,
    output logic [jbss_pkg::CNT_BITS-1:0]     wr_width,
    output logic [jbss_pkg::TOTAL_BITS-1:0]   total,
    output jbss_pkg::scan_stat_t              stat
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int CB = jbss_pkg::CNT_BITS;
    localparam int SW = jbss_pkg::PROD_BITS + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_GAP  = 4'b0100,
        S_SUM  = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        P_MARK_FWD   = 3'd0,
        P_MARK_BWD   = 3'd1,
        P_HEIGHT_FWD = 3'd2,
        P_SIZE_BWD   = 3'd3,
        P_WIDTH_FWD  = 3'd4
    } pass_t;

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v, input logic c);
        return (v == jbss_pkg::CNT_MAX) ? v : v + CB'(c);
    endfunction

    state_t                          state_reg, state_next;
    pass_t                           pass_reg, pass_next, pass_sel;
    logic [CW-1:0]                   n_reg, n_next, init_n;
    logic [CW-1:0]                   left_reg, left_next;
    logic [AW-1:0]                   addr_reg, addr_next;
    logic                            vld_reg, vld_next;
    logic [AW-1:0]                   waddr_reg, waddr_next;
    logic                            first_reg, first_next;
    logic [KEY_BITS-1:0]             prev_key_reg, prev_key_next;
    logic                            seen_reg, seen_next;
    logic [CB-1:0]                   h_reg, h_next;
    logic [CB-1:0]                   w_reg, w_next;
    logic [jbss_pkg::PROD_BITS-1:0]  prod_reg, prod_next;
    logic                            prod_vld_reg, prod_vld_next;
    logic [jbss_pkg::TOTAL_BITS-1:0] total_reg, total_next;
    logic [SW-1:0]                   sum;

    logic t1, fr, ci, same, seen_eff, start_pass, fwd;
    logic [CB-1:0] h_eff, w_eff;

    always_comb
    begin
        state_next    = state_reg;
        pass_next     = pass_reg;
        n_next        = n_reg;
        left_next     = left_reg;
        addr_next     = addr_reg;
        vld_next      = 1'b0;
        waddr_next    = waddr_reg;
        first_next    = first_reg;
        prev_key_next = prev_key_reg;
        seen_next     = seen_reg;
        h_next        = h_reg;
        w_next        = w_reg;
        prod_vld_next = 1'b0;
        start_pass    = 1'b0;
        pass_sel      = P_MARK_FWD;
        rd_en         = 1'b0;
        wr_en         = '0;
        wr_flag       = '0;
        wr_height     = '0;
        wr_width      = '0;

        t1       = rd_flag[jbss_pkg::FLAG_TAB];
        fr       = rd_flag[jbss_pkg::FLAG_FRESH];
        ci       = rd_flag[jbss_pkg::FLAG_CONTRIB];
        same     = !first_reg && (rd_key == prev_key_reg);
        seen_eff = same && seen_reg;
        h_eff    = same ? h_reg : '0;
        w_eff    = same ? w_reg : '0;

        prod_next = jbss_pkg::PROD_BITS'(rd_height) * jbss_pkg::PROD_BITS'(rd_width);

        // One stored entry is processed per cycle, in the cycle after its read.
        if (vld_reg)
        begin
            first_next    = 1'b0;
            prev_key_next = rd_key;
            case (pass_reg)
                P_MARK_FWD:
                begin
                    wr_en.flag = 1'b1;
                    wr_flag[jbss_pkg::FLAG_TAB]     = t1;
                    wr_flag[jbss_pkg::FLAG_FRESH]   = fr;
                    wr_flag[jbss_pkg::FLAG_CONTRIB] = fr || (t1 && seen_eff);
                    seen_next = seen_eff || (!t1 && fr);
                end
                P_MARK_BWD:
                begin
                    wr_en.flag = 1'b1;
                    wr_flag[jbss_pkg::FLAG_TAB]     = t1;
                    wr_flag[jbss_pkg::FLAG_FRESH]   = fr;
                    wr_flag[jbss_pkg::FLAG_CONTRIB] = ci || (!t1 && seen_eff);
                    seen_next = seen_eff || (t1 && fr);
                end
                P_HEIGHT_FWD:
                begin
                    wr_en.height = 1'b1;
                    wr_height    = (t1 && same) ? h_reg : '0;
                    if (!t1)
                    begin
                        h_next = same ? sat_inc(h_reg, ci) : CB'(ci);
                    end
                    else
                    begin
                        h_next = h_eff;
                    end
                end
                P_SIZE_BWD:
                begin
                    if (!t1)
                    begin
                        wr_en.height = 1'b1;
                        wr_en.width  = 1'b1;
                        wr_height    = h_eff;
                        wr_width     = w_eff;
                        h_next       = h_eff;
                        w_next       = w_eff;
                    end
                    else
                    begin
                        w_next = same ? sat_inc(w_reg, ci) : CB'(ci);
                        h_next = rd_height;
                    end
                end
                P_WIDTH_FWD:
                begin
                    if (!t1)
                    begin
                        w_next        = rd_width;
                        prod_vld_next = !same;
                    end
                    else
                    begin
                        wr_en.width = 1'b1;
                        wr_width    = w_eff;
                        w_next      = w_eff;
                    end
                end
                default:
                begin
                    wr_en = '0;
                end
            endcase
        end

        init_n = n_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    n_next = count;
                    init_n = count;
                    if (count == '0)
                    begin
                        state_next = S_SUM;
                    end
                    else
                    begin
                        start_pass = 1'b1;
                        pass_sel   = P_MARK_FWD;
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                rd_en      = 1'b1;
                vld_next   = 1'b1;
                waddr_next = addr_reg;
                left_next  = left_reg - 1'b1;
                addr_next  = (pass_reg inside {P_MARK_FWD, P_HEIGHT_FWD, P_WIDTH_FWD})
                             ? addr_reg + 1'b1 : addr_reg - 1'b1;
                if (left_reg == CW'(1))
                begin
                    state_next = S_GAP;
                end
            end
            S_GAP:
            begin
                if (pass_reg == P_WIDTH_FWD)
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    start_pass = 1'b1;
                    pass_sel   = pass_t'(pass_reg + 3'd1);
                    state_next = S_RUN;
                end
            end
            S_SUM:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        fwd = pass_sel inside {P_MARK_FWD, P_HEIGHT_FWD, P_WIDTH_FWD};
        if (start_pass)
        begin
            pass_next  = pass_sel;
            left_next  = init_n;
            addr_next  = fwd ? '0 : AW'(init_n - 1'b1);
            first_next = 1'b1;
            seen_next  = 1'b0;
            h_next     = '0;
            w_next     = '0;
        end

        sum        = SW'(total_reg) + SW'(prod_reg);
        total_next = total_reg;
        if (prod_vld_reg)
        begin
            total_next = (sum > SW'(jbss_pkg::TOTAL_MAX)) ? jbss_pkg::TOTAL_MAX
                                                           : jbss_pkg::TOTAL_BITS'(sum);
        end
        if (ctl.start || ctl.clear)
        begin
            total_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pass_reg     <= P_MARK_FWD;
            n_reg        <= '0;
            left_reg     <= '0;
            addr_reg     <= '0;
            vld_reg      <= 1'b0;
            first_reg    <= 1'b1;
            seen_reg     <= 1'b0;
            h_reg        <= '0;
            w_reg        <= '0;
            prod_vld_reg <= 1'b0;
            total_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pass_reg     <= pass_next;
            n_reg        <= n_next;
            left_reg     <= left_next;
            addr_reg     <= addr_next;
            vld_reg      <= vld_next;
            first_reg    <= first_next;
            seen_reg     <= seen_next;
            h_reg        <= h_next;
            w_reg        <= w_next;
            prod_vld_reg <= prod_vld_next;
            total_reg    <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        waddr_reg    <= waddr_next;
        prev_key_reg <= prev_key_next;
        prod_reg     <= prod_next;
    end

    assign rd_addr     = addr_reg;
    assign wr_addr     = waddr_reg;
    assign total       = total_reg;
    assign stat.busy   = (state_reg != S_IDLE);
    assign stat.finish = (state_reg == S_SUM);

endmodule

// ----- src/join_block_size_scan.sv -----
// A load beat is written in the cycle it is accepted; loads may follow back to back.
// A read result goes to the output registers once they are free; no beat is taken meanwhile.
// The load marked last starts five passes over the entry memory, one entry per cycle each,
// and the block takes no beat until the scan has finished.
// Reset clears the entry count, the total and the done flag; the entry memories keep no reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module join_block_size_scan #(
    parameter int MAX_ENTRIES = jbss_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = jbss_pkg::DEF_KEY_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic [jbss_pkg::IN_KEY_BITS-1:0]    join_key,
    input  logic                                source_table,
    input  logic                                fresh_entry,
    input  logic                                is_last,
    input  logic [jbss_pkg::INDEX_BITS-1:0]     read_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [jbss_pkg::INDEX_BITS-1:0]     entry_index,
    output logic                                contributes,
    output logic [jbss_pkg::CNT_BITS-1:0]       height_count,
    output logic [jbss_pkg::CNT_BITS-1:0]       width_count,
    output logic [jbss_pkg::TOTAL_BITS-1:0]     total_pairs
);

    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > jbss_pkg::INDEX_BITS) ? CW : jbss_pkg::INDEX_BITS;

    logic [CW-1:0] count_reg, count_next, base_count;
    logic          done_reg, done_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          rd_ok_reg;
    logic [jbss_pkg::INDEX_BITS-1:0] rd_idx_reg;
    logic          room, in_fire, load_fire, read_fire, in_range, xfer;

    logic                                out_valid_reg, out_valid_next;
    logic [jbss_pkg::INDEX_BITS-1:0]     entry_index_reg;
    logic                                contributes_reg;
    logic [jbss_pkg::CNT_BITS-1:0]       height_count_reg;
    logic [jbss_pkg::CNT_BITS-1:0]       width_count_reg;
    logic [jbss_pkg::TOTAL_BITS-1:0]     total_pairs_reg;

    logic                            st_rd_en;
    logic [AW-1:0]                   st_rd_addr;
    jbss_pkg::wr_en_t                st_wr_en;
    logic [AW-1:0]                   st_wr_addr;
    logic [KEY_BITS-1:0]             st_wr_key;
    logic [jbss_pkg::FLAG_BITS-1:0]  st_wr_flag, load_flag;
    logic [KEY_BITS-1:0]             rd_key;
    logic [jbss_pkg::FLAG_BITS-1:0]  rd_flag;
    logic [jbss_pkg::CNT_BITS-1:0]   rd_height, rd_width;

    logic                            sc_rd_en;
    logic [AW-1:0]                   sc_rd_addr;
    jbss_pkg::wr_en_t                sc_wr_en;
    logic [AW-1:0]                   sc_wr_addr;
    logic [jbss_pkg::FLAG_BITS-1:0]  sc_wr_flag;
    logic [jbss_pkg::CNT_BITS-1:0]   sc_wr_height, sc_wr_width;
    logic [jbss_pkg::TOTAL_BITS-1:0] sc_total;
    jbss_pkg::scan_ctl_t             scan_ctl;
    jbss_pkg::scan_stat_t            scan_stat;

    assign in_ready  = !scan_stat.busy && !rd_pend_reg;
    assign in_fire   = in_valid && in_ready;
    assign load_fire = in_fire && (req_type == jbss_pkg::REQ_LOAD);
    assign read_fire = in_fire && (req_type == jbss_pkg::REQ_READ);
    assign xfer      = rd_pend_reg && (!out_valid_reg || out_ready);

    assign scan_ctl.start = load_fire && is_last;
    assign scan_ctl.clear = load_fire && done_reg;

    always_comb
    begin
        base_count = done_reg ? '0 : count_reg;
        room       = base_count < CW'(MAX_ENTRIES);
        count_next = count_reg;
        if (load_fire)
        begin
            count_next = base_count + CW'(room);
        end

        done_next = done_reg;
        if (scan_stat.finish)
        begin
            done_next = 1'b1;
        end
        else if (load_fire)
        begin
            done_next = 1'b0;
        end

        in_range = done_reg && (CMPW'(read_index) < CMPW'(count_reg));

        rd_pend_next = rd_pend_reg;
        if (read_fire)
        begin
            rd_pend_next = 1'b1;
        end
        else if (xfer)
        begin
            rd_pend_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (xfer)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        load_flag                          = '0;
        load_flag[jbss_pkg::FLAG_TAB]      = source_table;
        load_flag[jbss_pkg::FLAG_FRESH]    = fresh_entry;

        st_wr_key = KEY_BITS'(join_key);
        if (scan_stat.busy)
        begin
            st_rd_en   = sc_rd_en;
            st_rd_addr = sc_rd_addr;
            st_wr_en   = sc_wr_en;
            st_wr_addr = sc_wr_addr;
            st_wr_flag = sc_wr_flag;
        end
        else
        begin
            st_rd_en        = read_fire;
            st_rd_addr      = AW'(read_index);
            st_wr_en        = '0;
            st_wr_en.key    = load_fire && room;
            st_wr_en.flag   = load_fire && room;
            st_wr_addr      = AW'(base_count);
            st_wr_flag      = load_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            done_reg      <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            done_reg      <= done_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (read_fire)
            begin
                rd_ok_reg <= in_range;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (read_fire)
        begin
            rd_idx_reg <= read_index;
        end
        if (xfer)
        begin
            entry_index_reg  <= rd_idx_reg;
            contributes_reg  <= rd_ok_reg && rd_flag[jbss_pkg::FLAG_CONTRIB];
            height_count_reg <= rd_ok_reg ? rd_height : '0;
            width_count_reg  <= rd_ok_reg ? rd_width : '0;
            total_pairs_reg  <= sc_total;
        end
    end

    jbss_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_store (
        .clk       (clk),
        .rd_en     (st_rd_en),
        .rd_addr   (st_rd_addr),
        .wr_en     (st_wr_en),
        .wr_addr   (st_wr_addr),
        .wr_key    (st_wr_key),
        .wr_flag   (st_wr_flag),
        .wr_height (sc_wr_height),
        .wr_width  (sc_wr_width),
        .rd_key    (rd_key),
        .rd_flag   (rd_flag),
        .rd_height (rd_height),
        .rd_width  (rd_width)
    );

    jbss_scan #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .count     (count_next),
        .rd_key    (rd_key),
        .rd_flag   (rd_flag),
        .rd_height (rd_height),
        .rd_width  (rd_width),
        .rd_en     (sc_rd_en),
        .rd_addr   (sc_rd_addr),
        .wr_en     (sc_wr_en),
        .wr_addr   (sc_wr_addr),
        .wr_flag   (sc_wr_flag),
        .wr_height (sc_wr_height),
        .wr_width  (sc_wr_width),
        .total     (sc_total),
        .stat      (scan_stat)
    );

    assign out_valid    = out_valid_reg;
    assign entry_index  = entry_index_reg;
    assign contributes  = contributes_reg;
    assign height_count = height_count_reg;
    assign width_count  = width_count_reg;
    assign total_pairs  = total_pairs_reg;

    `JBSS_ASSERT_NEXT(a_start_busy, clk, rst_n, scan_ctl.start, scan_stat.busy)
    `JBSS_ASSERT_NEXT(a_finish_done, clk, rst_n, scan_stat.finish, done_reg && !scan_stat.busy)
    `JBSS_ASSERT_NEXT(a_pend_out, clk, rst_n, xfer, out_valid_reg && !rd_pend_reg)
    `JBSS_ASSERT_NEXT(a_read_early, clk, rst_n, read_fire && !done_reg, !rd_ok_reg)
    `JBSS_ASSERT_SAME(a_busy_no_beat, clk, rst_n, scan_stat.busy || rd_pend_reg, !in_fire)

endmodule
